[src/uart_interrupt_ring_buffers_unit_assert.svh]
// Assertion macros used by the ring buffer datapath module.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef UART_INTERRUPT_RING_BUFFERS_UNIT_ASSERT_SVH
`define UART_INTERRUPT_RING_BUFFERS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define UIRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("uirb assertion failed");
`define UIRB_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("uirb forbidden condition seen");
`else
`define UIRB_ASSERT(lbl, prop)
`define UIRB_ASSERT_NEVER(lbl, expr)
`endif

`endif

[src/uirb_pkg.sv]
package uirb_pkg;

  localparam int unsigned RingDepthDefault = 256;

  localparam int unsigned IrqRxBit = 0;
  localparam int unsigned IrqTxBit = 1;

  typedef enum logic [1:0] {
    ActRead    = 2'd0,
    ActWrite   = 2'd1,
    ActTxReady = 2'd2,
    ActRxByte  = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       write_accepted;
    logic [7:0] line_byte;
    logic       line_valid;
    logic       rx_dropped;
    logic       rx_irq_enable;
    logic       tx_irq_enable;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // take the request from the input port
    logic load;     // move the result into the output register
  } cmd_t;

endpackage

[src/uirb_ctrl.sv]
module uirb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output uirb_pkg::cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StLoad
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_load;

  // output slot is free, or is being emptied this cycle
  assign can_load = !out_valid_q || out_ready_i;

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = (state_q == StIdle) && in_valid_i;
  assign cmd_o.load    = (state_q == StLoad) && can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StLoad;
        end
        StLoad: begin
          if (can_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if ((state_q == StLoad) && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[src/uirb_datapath.sv]
`include "uart_interrupt_ring_buffers_unit_assert.svh"

module uirb_datapath #(
  parameter int unsigned RING_DEPTH = uirb_pkg::RingDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  uirb_pkg::cmd_t cmd_i,
  input  uirb_pkg::in_t  in_i,
  output uirb_pkg::out_t out_o
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] PtrLast = PW'(RING_DEPTH - 1);

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  logic [7:0] rx_mem [RING_DEPTH];
  logic [7:0] tx_mem [RING_DEPTH];

  logic [PW-1:0] rx_rd_q, rx_rd_d, rx_wr_q, rx_wr_d;
  logic [PW-1:0] tx_rd_q, tx_rd_d, tx_wr_q, tx_wr_d;
  logic [1:0]    irq_q, irq_d;
  logic [7:0]    rx_rdata_q, tx_rdata_q;
  logic          read_valid_q, read_valid_d;
  logic          write_acc_q, write_acc_d;
  logic          line_valid_q, line_valid_d;
  logic          rx_drop_q, rx_drop_d;
  logic          rx_wr_en, tx_wr_en;
  logic          rx_empty, rx_full, tx_empty, tx_full;
  uirb_pkg::out_t out_q;

  assign rx_empty = (rx_rd_q == rx_wr_q);
  assign rx_full  = (rx_rd_q == nxt(rx_wr_q));
  assign tx_empty = (tx_rd_q == tx_wr_q);
  assign tx_full  = (tx_rd_q == nxt(tx_wr_q));

  always_comb begin
    rx_rd_d      = rx_rd_q;
    rx_wr_d      = rx_wr_q;
    tx_rd_d      = tx_rd_q;
    tx_wr_d      = tx_wr_q;
    irq_d        = irq_q;
    read_valid_d = 1'b0;
    write_acc_d  = 1'b0;
    line_valid_d = 1'b0;
    rx_drop_d    = 1'b0;
    rx_wr_en     = 1'b0;
    tx_wr_en     = 1'b0;
    case (uirb_pkg::action_e'(in_i.action))
      uirb_pkg::ActRead: begin
        irq_d[uirb_pkg::IrqRxBit] = 1'b1;
        if (!rx_empty) begin
          read_valid_d = 1'b1;
          rx_rd_d      = nxt(rx_rd_q);
        end
      end
      uirb_pkg::ActWrite: begin
        if (!tx_full) begin
          tx_wr_en    = 1'b1;
          tx_wr_d     = nxt(tx_wr_q);
          write_acc_d = 1'b1;
          irq_d[uirb_pkg::IrqTxBit] = 1'b1;
        end
      end
      uirb_pkg::ActTxReady: begin
        if (!tx_empty) begin
          line_valid_d = 1'b1;
          tx_rd_d      = nxt(tx_rd_q);
        end
      end
      uirb_pkg::ActRxByte: begin
        if (!rx_full) begin
          rx_wr_en = 1'b1;
          rx_wr_d  = nxt(rx_wr_q);
        end else begin
          rx_drop_d = 1'b1;
        end
      end
      default: ;
    endcase
    // UART events recompute both enables from occupancy after the update
    if ((in_i.action == uirb_pkg::ActTxReady) || (in_i.action == uirb_pkg::ActRxByte)) begin
      irq_d[uirb_pkg::IrqRxBit] = (rx_rd_d != nxt(rx_wr_d));
      irq_d[uirb_pkg::IrqTxBit] = (tx_rd_d != tx_wr_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_rd_q      <= '0;
      rx_wr_q      <= '0;
      tx_rd_q      <= '0;
      tx_wr_q      <= '0;
      irq_q        <= '0;
      read_valid_q <= 1'b0;
      write_acc_q  <= 1'b0;
      line_valid_q <= 1'b0;
      rx_drop_q    <= 1'b0;
    end else if (cmd_i.capture) begin
      rx_rd_q      <= rx_rd_d;
      rx_wr_q      <= rx_wr_d;
      tx_rd_q      <= tx_rd_d;
      tx_wr_q      <= tx_wr_d;
      irq_q        <= irq_d;
      read_valid_q <= read_valid_d;
      write_acc_q  <= write_acc_d;
      line_valid_q <= line_valid_d;
      rx_drop_q    <= rx_drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rx_rdata_q <= rx_mem[rx_rd_q];
      tx_rdata_q <= tx_mem[tx_rd_q];
    end
    if (rx_wr_en && cmd_i.capture) rx_mem[rx_wr_q] <= in_i.data_byte;
    if (tx_wr_en && cmd_i.capture) tx_mem[tx_wr_q] <= in_i.data_byte;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.read_data      <= read_valid_q ? rx_rdata_q : '0;
      out_q.read_valid     <= read_valid_q;
      out_q.write_accepted <= write_acc_q;
      out_q.line_byte      <= line_valid_q ? tx_rdata_q : '0;
      out_q.line_valid     <= line_valid_q;
      out_q.rx_dropped     <= rx_drop_q;
      out_q.rx_irq_enable  <= irq_q[uirb_pkg::IrqRxBit];
      out_q.tx_irq_enable  <= irq_q[uirb_pkg::IrqTxBit];
    end
  end

  assign out_o = out_q;

  `UIRB_ASSERT(rx_ptr_in_range, (rx_rd_q <= PtrLast) && (rx_wr_q <= PtrLast))
  `UIRB_ASSERT(tx_ptr_in_range, (tx_rd_q <= PtrLast) && (tx_wr_q <= PtrLast))
  `UIRB_ASSERT(rx_store_not_empty, cmd_i.capture && rx_wr_en |=> (rx_rd_q != rx_wr_q))
  `UIRB_ASSERT(tx_irq_after_write, cmd_i.capture && tx_wr_en |=> irq_q[uirb_pkg::IrqTxBit])

endmodule

[src/uart_interrupt_ring_buffers_unit.sv]
// Interrupt-driven UART ring buffers: a receive ring and a transmit ring of
// RING_DEPTH byte slots each, one slot always kept free.
// Input channel (in_valid_i / in_ready_o / in_i) carries one request: an
// action code and a data byte. Software read pops the receive ring, software
// write pushes the transmit ring, transmitter-ready moves one byte out to the
// line, received-byte stores a byte or drops it when the ring is full.
// Output channel (out_valid_o / out_ready_i / out_o) returns exactly one
// result per request, with the interrupt enables as they stand afterwards.
// Timing: a request is taken in state StIdle (ring update and registered memory
// read), the result is loaded into the output register in state StLoad, which
// raises out_valid_o. A new request is accepted only after the previous result
// has been loaded, since in_ready_o is high only in StIdle.
// A stalled receiver holds the result in the output register; the next
// request is still accepted but waits there, with in_ready_o low, until the
// output slot frees.
// Reset clears the ring pointers and both interrupt enables; ring contents
// are left as they are and never reach the output before being written.
module uart_interrupt_ring_buffers_unit #(
  parameter int unsigned RING_DEPTH = uirb_pkg::RingDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  uirb_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output uirb_pkg::out_t out_o
);

  uirb_pkg::cmd_t cmd;

  uirb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  uirb_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH = uirb_pkg::RingDepthDefault;
  localparam int unsigned HOLD_CYCLES = 80;

  // Shadow copy of both rings; every accepted request queues the reply it must produce.
  class uart_ring_scoreboard;
    logic [7:0]     rx_ring [DEPTH];
    logic [7:0]     tx_ring [DEPTH];
    int unsigned    rx_rd, rx_wr, tx_rd, tx_wr;
    logic           rx_irq, tx_irq;
    uirb_pkg::out_t replies_due [$];
    int             mismatches, replies_checked;
    int             rx_drops, tx_refusals, empty_reads, idle_polls;

    function new();
      rx_rd = 0;
      rx_wr = 0;
      tx_rd = 0;
      tx_wr = 0;
      rx_irq = 1'b0;
      tx_irq = 1'b0;
      mismatches = 0;
      replies_checked = 0;
      rx_drops = 0;
      tx_refusals = 0;
      empty_reads = 0;
      idle_polls = 0;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 == DEPTH) ? 0 : p + 1;
    endfunction

    // rx enable while the receive ring has room, tx enable while bytes wait to go out
    function void refresh_enables();
      rx_irq = (next_slot(rx_wr) != rx_rd);
      tx_irq = (tx_rd != tx_wr);
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void note_request(uirb_pkg::in_t req);
      uirb_pkg::out_t r;
      r = '0;
      case (uirb_pkg::action_e'(req.action))
        uirb_pkg::ActRead: begin
          rx_irq = 1'b1;
          if (rx_rd != rx_wr) begin
            r.read_data  = rx_ring[rx_rd];
            r.read_valid = 1'b1;
            rx_rd = next_slot(rx_rd);
          end else begin
            empty_reads++;
          end
        end
        uirb_pkg::ActWrite: begin
          if (next_slot(tx_wr) != tx_rd) begin
            tx_ring[tx_wr] = req.data_byte;
            tx_wr = next_slot(tx_wr);
            tx_irq = 1'b1;
            r.write_accepted = 1'b1;
          end else begin
            tx_refusals++;
          end
        end
        uirb_pkg::ActTxReady: begin
          if (tx_rd != tx_wr) begin
            r.line_byte  = tx_ring[tx_rd];
            r.line_valid = 1'b1;
            tx_rd = next_slot(tx_rd);
          end else begin
            idle_polls++;
          end
          refresh_enables();
        end
        default: begin
          if (next_slot(rx_wr) != rx_rd) begin
            rx_ring[rx_wr] = req.data_byte;
            rx_wr = next_slot(rx_wr);
          end else begin
            r.rx_dropped = 1'b1;
            rx_drops++;
          end
          refresh_enables();
        end
      endcase
      r.rx_irq_enable = rx_irq;
      r.tx_irq_enable = tx_irq;
      replies_due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("reply %0d: %s = 0x%0h, expected 0x%0h",
                                  replies_checked, name, got, want));
    endtask

    task check_result(uirb_pkg::out_t got);
      uirb_pkg::out_t want;
      if (replies_due.size() == 0) begin
        report_mismatch("reply seen with no request outstanding");
      end else begin
        want = replies_due.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
        check_field("write_accepted", 8'(got.write_accepted), 8'(want.write_accepted));
        check_field("line_byte", got.line_byte, want.line_byte);
        check_field("line_valid", 8'(got.line_valid), 8'(want.line_valid));
        check_field("rx_dropped", 8'(got.rx_dropped), 8'(want.rx_dropped));
        check_field("rx_irq_enable", 8'(got.rx_irq_enable), 8'(want.rx_irq_enable));
        check_field("tx_irq_enable", 8'(got.tx_irq_enable), 8'(want.tx_irq_enable));
        replies_checked++;
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  uirb_pkg::in_t  in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  uirb_pkg::out_t out_reply;

  uart_ring_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_starts = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int requests_sent = 0;
  int input_stall_cycles = 0;

  uart_interrupt_ring_buffers_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_reply)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk_i) begin
    if (hold_starts != hold_seen) begin
      hold_seen <= hold_starts;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) sb.check_result(out_reply);
      if (in_valid && !in_ready) input_stall_cycles++;
    end
  end

  task automatic send_request(input uirb_pkg::in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic issue(input uirb_pkg::action_e act, input logic [7:0] data);
    uirb_pkg::in_t req;
    req.action    = act;
    req.data_byte = data;
    send_request(req);
  endtask

  // weights in percent for read, write and tx-ready; received bytes take the rest
  task automatic random_request(input int w_rd, input int w_wr, input int w_txr);
    uirb_pkg::in_t req;
    int  roll;
    roll = $urandom_range(99);
    if (roll < w_rd) req.action = uirb_pkg::ActRead;
    else if (roll < w_rd + w_wr) req.action = uirb_pkg::ActWrite;
    else if (roll < w_rd + w_wr + w_txr) req.action = uirb_pkg::ActTxReady;
    else req.action = uirb_pkg::ActRxByte;
    req.data_byte = 8'($urandom_range(255));
    send_request(req);
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty rings first, then small pushes and pops with edge data values
    issue(uirb_pkg::ActRead, 8'hFF);
    issue(uirb_pkg::ActTxReady, 8'hFF);
    issue(uirb_pkg::ActWrite, 8'h00);
    issue(uirb_pkg::ActWrite, 8'hFF);
    issue(uirb_pkg::ActWrite, 8'hA5);
    issue(uirb_pkg::ActTxReady, 8'h00);
    issue(uirb_pkg::ActTxReady, 8'h00);
    issue(uirb_pkg::ActRxByte, 8'h00);
    issue(uirb_pkg::ActRxByte, 8'hFF);
    issue(uirb_pkg::ActRxByte, 8'h5A);
    issue(uirb_pkg::ActRead, 8'h00);
    issue(uirb_pkg::ActRead, 8'h00);
    issue(uirb_pkg::ActRead, 8'h00);
    issue(uirb_pkg::ActRead, 8'h00);
    issue(uirb_pkg::ActTxReady, 8'h00);
    issue(uirb_pkg::ActTxReady, 8'h00);
    issue(uirb_pkg::ActWrite, 8'h3C);
    issue(uirb_pkg::ActRxByte, 8'hC3);
    wait_all_replies();

    // no sender idling, one receiver hold-off: fill the receive ring until bytes get dropped, tx ring partly
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    for (int n = 0; n < 700 && sb.rx_drops < 6; n++) begin
      if (n == 20) hold_starts <= hold_starts + 1;
      random_request(2, 36, 2);
    end
    wait_all_replies();

    // sender idles: push the transmit ring until writes are refused
    send_idle_pct = 45;
    recv_stall_pct <= 0;
    for (int n = 0; n < 500 && sb.tx_refusals < 6; n++) random_request(10, 85, 3);
    wait_all_replies();

    // receiver stalls: mostly draining both rings
    send_idle_pct = 0;
    recv_stall_pct <= 45;
    repeat (60) random_request(45, 5, 45);
    wait_all_replies();

    // light idling on both sides, even mix
    send_idle_pct = 10;
    recv_stall_pct <= 10;
    repeat (60) random_request(25, 25, 25);
    wait_all_replies();

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d replies never arrived", sb.pending()));

    $display("Covered %0d requests, %0d replies checked: %0d rx drops, %0d tx refusals",
             requests_sent, sb.replies_checked, sb.rx_drops, sb.tx_refusals);
    $display("%0d reads on empty ring, %0d idle tx polls, input stalled %0d cycles",
             sb.empty_reads, sb.idle_polls, input_stall_cycles);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: ring unit stopped answering");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
